/* rtl/query_param_extract_decode_macros.svh */
// assertion macros for the query parameter extract and decode block
// used by the checker; expects signals named clock and reset in scope
`ifndef QUERY_PARAM_EXTRACT_DECODE_MACROS_SVH
`define QUERY_PARAM_EXTRACT_DECODE_MACROS_SVH

// same-cycle implication, off while reset is high
`define QPE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qpe check failed: same-cycle implication");

// next-cycle implication, off while reset is high
`define QPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qpe check failed: next-cycle implication");

// state seen in the cycle after reset is high
`define QPE_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("qpe check failed: state after reset");

`endif

/* rtl/qpe_pkg.sv */
// shared constants, types and helper functions of the query parameter decoder
// no dependencies; imported by the other files but the macros and the checker
`timescale 1ns / 1ps

package qpe_pkg;

   localparam int MAX_KEY_BYTES   = 8;
   localparam int RAW_VALUE_LIMIT = 1023;

   localparam int KEY_W   = 64;
   localparam int LEN_W   = 4;
   localparam int LIMIT_W = 16;
   localparam int POS_W   = $clog2(MAX_KEY_BYTES + 1);
   localparam int RAW_W   = $clog2(RAW_VALUE_LIMIT + 1);

   localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 16'd1024;

   // csr register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_BYTES  = 2'd0,
      CSR_KEY_LENGTH = 2'd1,
      CSR_OUT_LIMIT  = 2'd2
   } csr_index_type;

   // characters
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;

   // one byte can cause at most three result bytes
   localparam int BURST_MAX   = 3;
   localparam int BURST_IDX_W = $clog2(BURST_MAX);
   localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

   // record queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // results caused by one query byte
   typedef struct packed {
      logic [BURST_MAX-1:0][7:0]  data;
      logic [BURST_CNT_W-1:0]     count;
      logic                       last;
      logic                       found;
   } burst_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c inside {[CHAR_0:CHAR_9], [CHAR_UA:CHAR_UF], [CHAR_LA:CHAR_LF]});
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c inside {[CHAR_0:CHAR_9]}) begin
         v = c[3:0];
      end else if (c inside {[CHAR_UA:CHAR_UF], [CHAR_LA:CHAR_LF]}) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

/* rtl/qpe_channels_if.sv */
// channel interfaces of the query parameter decoder: query bytes, results, csr writes
// depends on qpe_pkg
`timescale 1ns / 1ps

interface qpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] query_byte;
   logic       query_last;

   modport source (output valid, output query_byte, output query_last, input ready);
   modport sink   (input valid, input query_byte, input query_last, output ready);
   modport monitor (input valid, input query_byte, input query_last, input ready);
endinterface

interface qpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic       has_byte;
   logic       key_found;
   logic       final_result;

   modport source (output valid, output value_byte, output has_byte, output key_found,
                   output final_result, input ready);
   modport sink   (input valid, input value_byte, input has_byte, input key_found,
                   input final_result, output ready);
   modport monitor (input valid, input value_byte, input has_byte, input key_found,
                    input final_result, input ready);
endinterface

interface qpe_csr_if import qpe_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [KEY_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/qpe_front.sv */
// front part: csr registers, key search and percent decode of each query byte
// depends on qpe_pkg and qpe_channels_if; at most one burst record per byte
`timescale 1ns / 1ps

module qpe_front import qpe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qpe_req_if.sink   req_chan,
   qpe_csr_if.sink   csr_chan,
   input  logic      queue_full,
   output logic      push_valid,
   output burst_type push_burst
);

   typedef enum logic [1:0] {
      PHASE_SEARCH,
      PHASE_VALUE,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_ONE,
      PEND_TWO
   } pend_type;

   typedef struct packed {
      logic [BURST_MAX-1:0][7:0] data;
      logic [BURST_CNT_W-1:0]    count;
   } cand_type;

   function automatic cand_type push_cand(input cand_type c, input logic [7:0] x);
      cand_type r;
      r = c;
      if (r.count != BURST_CNT_W'(BURST_MAX)) begin
         r.data[r.count[BURST_IDX_W-1:0]] = x;
         r.count = r.count + 1'b1;
      end
      return r;
   endfunction

   // csr registers
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [LEN_W-1:0]   key_len_ff, key_len_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   // query state
   phase_type                          phase_ff, phase_in;
   logic [POS_W-1:0]                   fpos_ff, fpos_in;
   logic [MAX_KEY_BYTES-1:0][7:0]      win_ff, win_in;
   logic [MAX_KEY_BYTES-1:0]           starts_ff, starts_in;
   pend_type                           pend_cnt_ff, pend_cnt_in;
   logic [7:0]                         pend_hex_ff, pend_hex_in;
   logic [LIMIT_W-1:0]                 emitted_ff, emitted_in;
   logic [RAW_W-1:0]                   raw_ff, raw_in;

   logic                     accept;
   logic [7:0]               b;
   logic                     last;
   logic [POS_W-1:0]         len;
   logic                     starts_field;
   logic [MAX_KEY_BYTES:0]   cand_hit;
   logic                     hit;
   cand_type                 c;
   pend_type                 p_cnt;
   logic [7:0]               p_hex;
   logic                     taken;
   logic [RAW_W-1:0]         raw_next;
   logic                     value_end;
   logic [LIMIT_W:0]         room;
   logic [BURST_CNT_W-1:0]   avail;
   logic [BURST_CNT_W-1:0]   n_acc;

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && req_chan.ready;
   assign b      = req_chan.query_byte;
   assign last   = req_chan.query_last;

   // key match, one candidate per key length
   always_comb begin
      logic m;
      len = (key_len_ff > LEN_W'(MAX_KEY_BYTES)) ? POS_W'(MAX_KEY_BYTES)
                                                : POS_W'(key_len_ff);
      starts_field = (fpos_ff == '0) || (win_ff[0] == CHAR_AMP);
      cand_hit[0] = starts_field;
      for (int l = 1; l <= MAX_KEY_BYTES; l++) begin
         m = 1'b1;
         for (int j = 0; j < l; j++) begin
            if (key_ff[8*j +: 8] != win_ff[l-1-j]) m = 1'b0;
         end
         cand_hit[l] = m && starts_ff[l-1] && (fpos_ff >= POS_W'(l));
      end
      hit = (limit_ff != '0) && (b == CHAR_EQ) && cand_hit[len];
   end

   // percent decode and value end flush
   always_comb begin
      c     = '0;
      p_cnt = pend_cnt_ff;
      p_hex = pend_hex_ff;
      taken = 1'b0;
      if (p_cnt == PEND_TWO) begin
         if (is_hex(b)) begin
            c     = push_cand(c, {hex_value(p_hex), hex_value(b)});
            p_cnt = PEND_NONE;
            taken = 1'b1;
         end else begin
            c     = push_cand(c, CHAR_PCT);
            c     = push_cand(c, p_hex);
            p_cnt = PEND_NONE;
         end
      end else if (p_cnt == PEND_ONE) begin
         if (is_hex(b)) begin
            p_hex = b;
            p_cnt = PEND_TWO;
            taken = 1'b1;
         end else begin
            c     = push_cand(c, CHAR_PCT);
            p_cnt = PEND_NONE;
         end
      end
      if (!taken) begin
         if (b == CHAR_PCT) p_cnt = PEND_ONE;
         else if (b == CHAR_PLUS) c = push_cand(c, CHAR_SPACE);
         else c = push_cand(c, b);
      end

      raw_next  = raw_ff + 1'b1;
      value_end = (b == CHAR_AMP) || (raw_next >= RAW_W'(RAW_VALUE_LIMIT)) || last;

      // the separator itself is not part of the value
      if (b == CHAR_AMP) begin
         c     = '0;
         p_cnt = pend_cnt_ff;
         p_hex = pend_hex_ff;
      end
      if (value_end) begin
         if (p_cnt != PEND_NONE) c = push_cand(c, CHAR_PCT);
         if (p_cnt == PEND_TWO) c = push_cand(c, p_hex);
         p_cnt = PEND_NONE;
      end

      // output limit: room for limit - 1 - emitted bytes
      room = {1'b0, limit_ff} - {1'b0, emitted_ff} - 1'b1;
      if (room[LIMIT_W] || room == '0) avail = '0;
      else if (room >= (LIMIT_W+1)'(BURST_MAX)) avail = BURST_CNT_W'(BURST_MAX);
      else avail = room[BURST_CNT_W-1:0];
      n_acc = (c.count < avail) ? c.count : avail;
   end

   // next state
   always_comb begin
      key_in      = key_ff;
      key_len_in  = key_len_ff;
      limit_in    = limit_ff;
      phase_in    = phase_ff;
      fpos_in     = fpos_ff;
      win_in      = win_ff;
      starts_in   = starts_ff;
      pend_cnt_in = pend_cnt_ff;
      pend_hex_in = pend_hex_ff;
      emitted_in  = emitted_ff;
      raw_in      = raw_ff;
      push_valid  = 1'b0;
      push_burst  = '0;

      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_KEY_BYTES:  key_in     = csr_chan.data;
            CSR_KEY_LENGTH: key_len_in = csr_chan.data[LEN_W-1:0];
            CSR_OUT_LIMIT:  limit_in   = csr_chan.data[LIMIT_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         case (phase_ff)
            PHASE_SEARCH: begin
               for (int k = MAX_KEY_BYTES - 1; k > 0; k--) begin
                  win_in[k]    = win_ff[k-1];
                  starts_in[k] = starts_ff[k-1];
               end
               win_in[0]    = b;
               starts_in[0] = starts_field;
               if (fpos_ff < POS_W'(MAX_KEY_BYTES)) fpos_in = fpos_ff + 1'b1;
               if (hit) begin
                  phase_in    = PHASE_VALUE;
                  pend_cnt_in = PEND_NONE;
                  pend_hex_in = '0;
                  emitted_in  = '0;
                  raw_in      = '0;
               end
               if (last) begin
                  push_valid       = 1'b1;
                  push_burst.last  = 1'b1;
                  push_burst.found = hit;
               end
            end
            PHASE_VALUE: begin
               if (b != CHAR_AMP) raw_in = raw_next;
               pend_cnt_in      = p_cnt;
               pend_hex_in      = p_hex;
               emitted_in       = emitted_ff + LIMIT_W'(n_acc);
               push_burst.data  = c.data;
               push_burst.count = n_acc;
               push_burst.last  = value_end;
               push_burst.found = value_end;
               push_valid       = value_end || (n_acc != '0);
               if (value_end) phase_in = PHASE_DONE;
            end
            PHASE_DONE: ;
            default: ;
         endcase

         // fresh query after the last byte
         if (last) begin
            phase_in    = PHASE_SEARCH;
            fpos_in     = '0;
            win_in      = '0;
            starts_in   = '0;
            pend_cnt_in = PEND_NONE;
            pend_hex_in = '0;
            emitted_in  = '0;
            raw_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         key_len_ff  <= '0;
         limit_ff    <= OUT_LIMIT_RESET;
         phase_ff    <= PHASE_SEARCH;
         fpos_ff     <= '0;
         win_ff      <= '0;
         starts_ff   <= '0;
         pend_cnt_ff <= PEND_NONE;
         pend_hex_ff <= '0;
         emitted_ff  <= '0;
         raw_ff      <= '0;
      end else begin
         key_ff      <= key_in;
         key_len_ff  <= key_len_in;
         limit_ff    <= limit_in;
         phase_ff    <= phase_in;
         fpos_ff     <= fpos_in;
         win_ff      <= win_in;
         starts_ff   <= starts_in;
         pend_cnt_ff <= pend_cnt_in;
         pend_hex_ff <= pend_hex_in;
         emitted_ff  <= emitted_in;
         raw_ff      <= raw_in;
      end
   end

endmodule

/* rtl/qpe_queue.sv */
// small register queue of burst records between the front and back parts
// depends on qpe_pkg
`timescale 1ns / 1ps

module qpe_queue import qpe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  burst_type push_burst,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output burst_type head_burst
);

   burst_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_burst = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_burst;
   end

endmodule

/* rtl/qpe_back.sv */
// back part: walks the head burst record and sends one result per transaction
// depends on qpe_pkg and qpe_channels_if
`timescale 1ns / 1ps

module qpe_back import qpe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  burst_type head_burst,
   output logic      pop,
   qpe_rsp_if.source rsp_chan
);

   logic [BURST_IDX_W-1:0] sub_ff, sub_in;
   logic                   empty_rec;
   logic                   at_last;
   logic                   is_final;
   logic                   sent;

   assign empty_rec = (head_burst.count == '0);
   assign at_last   = empty_rec ||
                      (BURST_CNT_W'(sub_ff) == head_burst.count - 1'b1);
   assign is_final  = at_last && head_burst.last;

   assign rsp_chan.valid        = head_valid;
   assign rsp_chan.value_byte   = empty_rec ? 8'd0 : head_burst.data[sub_ff];
   assign rsp_chan.has_byte     = !empty_rec;
   assign rsp_chan.final_result = is_final;
   assign rsp_chan.key_found    = is_final && head_burst.found;

   assign sent = rsp_chan.valid && rsp_chan.ready;
   assign pop  = sent && at_last;

   always_comb begin
      sub_in = sub_ff;
      if (sent) sub_in = at_last ? '0 : sub_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

/* rtl/query_param_extract_decode.sv */
// query parameter extract and percent decode: top level
// depends on qpe_pkg, qpe_channels_if, qpe_front, qpe_queue and qpe_back
//
// usage
//   req_chan carries the query one byte per transaction, query_last on the
//   final byte. csr_chan writes key_bytes (0), key_length (1), out_limit (2);
//   it is always ready; the user must write it only while the block is idle
//   (the block does not enforce it). rsp_chan gives decoded value bytes of the
//   first field named by the key, then the query's final result with key_found.
// throughput
//   one query byte per cycle while the record queue has room; the result port
//   sends one result per cycle while rsp_chan is ready, and a byte can cause
//   at most 3 results, from a broken escape or a value end flush. a byte's
//   burst record is registered in the queue before its first result shows on
//   rsp_chan.
// reset
//   synchronous, active high; clears the csr registers (out_limit to 1024),
//   the query state and the queue. no clearing pass.
// stall
//   a stalled result holds; the front keeps taking bytes until the four-entry
//   record queue fills, then drops req_chan.ready.
`timescale 1ns / 1ps

module query_param_extract_decode import qpe_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qpe_req_if.sink   req_chan,
   qpe_rsp_if.source rsp_chan,
   qpe_csr_if.sink   csr_chan
);

   // front to queue
   logic      queue_full;
   logic      push_valid;
   burst_type push_burst;

   // queue to back
   logic      head_valid;
   burst_type head_burst;
   logic      pop;

   // byte classification: key search, decode, output limit, burst build
   qpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_burst (push_burst)
   );

   // decouples byte intake from result delivery
   qpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_burst (push_burst),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_burst (head_burst)
   );

   // one result per transaction from the head record
   qpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_burst (head_burst),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* rtl/qpe_checker.sv */
// port-level checks of the query parameter decoder, bound to the top level
// depends on query_param_extract_decode_macros.svh and the top level's channel ports
`timescale 1ns / 1ps
`include "query_param_extract_decode_macros.svh"

module qpe_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_has_byte,
   input logic rsp_key_found,
   input logic rsp_final_result
);

   // a stalled result stays offered
   `QPE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // reset empties the queue and opens the input
   `QPE_ASSERT_AFTER_RESET(a_reset_state, !rsp_valid && req_ready)

   // results only follow an accepted byte
   `QPE_ASSERT_SAME(a_rsp_cause, $rose(rsp_valid), $past(req_valid && req_ready))

   // key_found and empty results come only on the final result
   `QPE_ASSERT_SAME(a_final_only, rsp_valid && (rsp_key_found || !rsp_has_byte), rsp_final_result)

endmodule

bind query_param_extract_decode qpe_checker u_qpe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_has_byte     (rsp_chan.has_byte),
   .rsp_key_found    (rsp_chan.key_found),
   .rsp_final_result (rsp_chan.final_result)
);

/* tb/query_param_extract_decode_tb.sv */
// testbench for the query parameter extract and percent decode block
// self-checking, with its own prediction of every result; needs qpe_pkg,
// qpe_channels_if and the rtl of query_param_extract_decode
`timescale 1ns / 1ps

module query_param_extract_decode_tb import qpe_pkg::*; ;

   // one result transaction as the block should send it
   typedef struct packed {
      logic [7:0] value_byte;
      logic       has_byte;
      logic       key_found;
      logic       final_result;
   } value_result_type;

   // where the predicted scan stands within the current query
   typedef enum logic [1:0] {
      SEEK_KEY,
      IN_VALUE,
      SKIP_REST
   } scan_phase_type;

   logic clock = 1'b0;
   logic reset;

   qpe_req_if req_chan ();
   qpe_rsp_if rsp_chan ();
   qpe_csr_if csr_chan ();

   query_param_extract_decode dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #5 clock = ~clock;

   // register copies kept in step with every csr transaction
   logic [KEY_W-1:0]   cfg_key;
   logic [LEN_W-1:0]   cfg_key_length;
   logic [LIMIT_W-1:0] cfg_out_limit;

   // predicted scan state
   scan_phase_type scan_phase;
   int unsigned    name_pos;
   logic [7:0]     recent_bytes [MAX_KEY_BYTES];
   logic           field_start_seen [MAX_KEY_BYTES+1];
   int unsigned    esc_count;
   logic [7:0]     esc_digit;
   int unsigned    decoded_count;
   int unsigned    raw_taken;
   logic [7:0]     burst_bytes [$];

   // results still owed by the block, oldest first
   value_result_type value_results [$];

   // query under construction, sent by send_query
   logic [7:0] query_text [$];

   int unsigned src_idle_pct;
   int unsigned sink_idle_pct;
   int unsigned stall_request;
   int unsigned stall_left;
   int unsigned bytes_accepted;
   int unsigned queries_seen;
   int unsigned results_checked;
   int unsigned error_count;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   function automatic void restart_query();
      scan_phase    = SEEK_KEY;
      name_pos      = 0;
      esc_count     = 0;
      esc_digit     = 8'd0;
      decoded_count = 0;
      raw_taken     = 0;
      for (int k = 0; k < MAX_KEY_BYTES; k++) recent_bytes[k] = 8'd0;
      for (int k = 0; k <= MAX_KEY_BYTES; k++) field_start_seen[k] = 1'b0;
   endfunction

   function automatic bit hex_char(logic [7:0] c);
      return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UF)
         || (c >= CHAR_LA && c <= CHAR_LF);
   endfunction

   // only called on hex characters
   function automatic logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      if (c <= CHAR_9) v = c - CHAR_0;
      else if (c >= CHAR_LA) v = c - CHAR_LA + 8'd10;
      else v = c - CHAR_UA + 8'd10;
      return v[3:0];
   endfunction

   // one decoded byte, subject to the output limit and the burst size
   function automatic void put_decoded(logic [7:0] v);
      if (cfg_out_limit == 0 || decoded_count + 1 >= cfg_out_limit) return;
      if (burst_bytes.size() >= BURST_MAX) return;
      burst_bytes.push_back(v);
      decoded_count++;
   endfunction

   function automatic void flush_escape();
      if (esc_count >= 1) put_decoded(CHAR_PCT);
      if (esc_count == 2) put_decoded(esc_digit);
      esc_count = 0;
   endfunction

   function automatic void decode_char(logic [7:0] b);
      if (esc_count == 2) begin
         if (hex_char(b)) begin
            put_decoded({nibble_of(esc_digit), nibble_of(b)});
            esc_count = 0;
            return;
         end
         put_decoded(CHAR_PCT);
         put_decoded(esc_digit);
         esc_count = 0;
      end else if (esc_count == 1) begin
         if (hex_char(b)) begin
            esc_digit = b;
            esc_count = 2;
            return;
         end
         put_decoded(CHAR_PCT);
         esc_count = 0;
      end
      if (b == CHAR_PCT) esc_count = 1;
      else if (b == CHAR_PLUS) put_decoded(CHAR_SPACE);
      else put_decoded(b);
   endfunction

   // queue the burst; a closing burst carries the final flag on its last
   // entry, or on an empty result when it holds no data
   function automatic void post_burst(bit closing, bit found);
      value_result_type r;
      if (closing && burst_bytes.size() == 0) begin
         r = '{value_byte: 8'd0, has_byte: 1'b0, key_found: found, final_result: 1'b1};
         value_results.push_back(r);
      end
      foreach (burst_bytes[k]) begin
         r.value_byte   = burst_bytes[k];
         r.has_byte     = 1'b1;
         r.final_result = closing && (k == burst_bytes.size() - 1);
         r.key_found    = r.final_result && found;
         value_results.push_back(r);
      end
   endfunction

   // shift one byte into the name window; true when it is the '=' ending
   // a field whose name equals the key, with a nonzero output limit
   function automatic bit scan_name(logic [7:0] b);
      int unsigned len;
      bit          starts;
      bit          hit;
      len = (cfg_key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : cfg_key_length;
      starts = (name_pos == 0) || (recent_bytes[0] == CHAR_AMP);
      for (int k = MAX_KEY_BYTES; k > 0; k--) field_start_seen[k] = field_start_seen[k-1];
      field_start_seen[0] = starts;
      hit = (cfg_out_limit != 0) && (b == CHAR_EQ) && (name_pos >= len)
         && field_start_seen[len];
      for (int j = 0; j < len; j++) begin
         if (cfg_key[8*j +: 8] != recent_bytes[len-1-j]) hit = 1'b0;
      end
      for (int k = MAX_KEY_BYTES - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
      recent_bytes[0] = b;
      if (name_pos < MAX_KEY_BYTES) name_pos++;
      return hit;
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic is_last);
      bit closing;
      burst_bytes.delete();
      case (scan_phase)
         SEEK_KEY: begin
            if (scan_name(b)) begin
               scan_phase    = IN_VALUE;
               esc_count     = 0;
               esc_digit     = 8'd0;
               decoded_count = 0;
               raw_taken     = 0;
               if (is_last) begin
                  post_burst(1'b1, 1'b1);
                  restart_query();
               end
            end else if (is_last) begin
               post_burst(1'b1, 1'b0);
               restart_query();
            end
         end
         IN_VALUE: begin
            closing = (b == CHAR_AMP);
            if (!closing) begin
               if (raw_taken < RAW_VALUE_LIMIT) begin
                  raw_taken++;
                  decode_char(b);
               end
               closing = (raw_taken >= RAW_VALUE_LIMIT) || is_last;
            end
            if (closing) begin
               flush_escape();
               post_burst(1'b1, 1'b1);
               scan_phase = SKIP_REST;
               if (is_last) restart_query();
            end else begin
               post_burst(1'b0, 1'b0);
            end
         end
         default: begin
            if (is_last) restart_query();
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // monitors: predict on every accepted query byte, check every result
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_byte(req_chan.query_byte, req_chan.query_last);
         bytes_accepted++;
         if (req_chan.query_last) queries_seen++;
      end
   end

   always @(posedge clock) begin : check_results
      value_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_checked++;
         if (value_results.size() == 0) begin
            $error("result transaction with nothing expected: byte %0h has %0b",
                   rsp_chan.value_byte, rsp_chan.has_byte);
            error_count++;
         end else begin
            want = value_results.pop_front();
            if (rsp_chan.value_byte !== want.value_byte) begin
               $error("value_byte: expected %0h, actual %0h", want.value_byte,
                      rsp_chan.value_byte);
               error_count++;
            end
            if (rsp_chan.has_byte !== want.has_byte) begin
               $error("has_byte: expected %0b, actual %0b", want.has_byte, rsp_chan.has_byte);
               error_count++;
            end
            if (rsp_chan.key_found !== want.key_found) begin
               $error("key_found: expected %0b, actual %0b", want.key_found,
                      rsp_chan.key_found);
               error_count++;
            end
            if (rsp_chan.final_result !== want.final_result) begin
               $error("final_result: expected %0b, actual %0b", want.final_result,
                      rsp_chan.final_result);
               error_count++;
            end
         end
      end
   end

   // result receiver: random idling, or a long hold-off when a test asks
   // for one; the count runs here so the sender keeps pushing meanwhile
   initial begin
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
      forever begin
         @(negedge clock);
         if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left != 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // one query byte; valid stays high into the next byte unless a gap
   // is drawn, so back-to-back transactions happen too
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.query_byte <= b;
      req_chan.query_last <= is_last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_query();
      for (int i = 0; i < query_text.size(); i++) begin
         send_byte(query_text[i], i == query_text.size() - 1);
      end
      query_text.delete();
   endtask

   // block idle: query input dropped and every owed result in
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (value_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [KEY_W-1:0] data);
      settle();
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_KEY_BYTES:  cfg_key        = data;
         CSR_KEY_LENGTH: cfg_key_length = data[LEN_W-1:0];
         CSR_OUT_LIMIT:  cfg_out_limit  = data[LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // key text packed first character lowest; length given separately so
   // an overlong length can be written
   task automatic set_key(input string s, input int unsigned len);
      logic [KEY_W-1:0] bits;
      bits = '0;
      for (int i = 0; i < s.len(); i++) bits[8*i +: 8] = s[i];
      csr_write(CSR_KEY_BYTES, bits);
      csr_write(CSR_KEY_LENGTH, KEY_W'(len));
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) query_text.push_back(s[i]);
   endtask

   function automatic logic [7:0] pick_char(string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   // value content: mostly escapes, hex digits and plus signs, plus noise
   function automatic logic [7:0] value_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 30) return pick_char("0123456789abcdefABCDEF");
      if (pick < 45) return CHAR_PCT;
      if (pick < 55) return CHAR_PLUS;
      if (pick < 60) return CHAR_EQ;
      return 8'($urandom_range(255, 1));
   endfunction

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset leaves an empty key, so '=' at the start of a field matches;
   // a plus sign and a broken escape in the value
   task automatic test_reset_defaults();
      add_text("=+%4g");
      send_query();
   endtask

   task automatic test_percent_decoding();
      set_key("id", 2);
      // key inside a name is no match; escapes of both cases, open
      // escape flushed at the ampersand, trailing bytes ignored
      add_text("xid=1&id=%7e%4A+%&z");
      send_query();
      // escape cut by the end of the query after one hex digit
      add_text("id=%4");
      send_query();
   endtask

   task automatic test_missing_key();
      add_text("idd=1");
      send_query();
   endtask

   task automatic test_literal_key_chars();
      // separators inside the key compare literally
      set_key("a&b", 3);
      add_text("a&b=1");
      send_query();
      // all-ones key with a length above the window acts as eight bytes
      csr_write(CSR_KEY_BYTES, '1);
      csr_write(CSR_KEY_LENGTH, 64'd15);
      repeat (8) query_text.push_back(8'hFF);
      add_text("=q");
      send_query();
      // a zero key character never matches: key is zero then 'a'
      csr_write(CSR_KEY_BYTES, 64'h0000_0000_0000_6100);
      csr_write(CSR_KEY_LENGTH, 64'd2);
      add_text("xa=1");
      send_query();
   endtask

   task automatic test_output_limit();
      set_key("id", 2);
      // zero limit: never found
      csr_write(CSR_OUT_LIMIT, '0);
      add_text("id=1");
      send_query();
      // limit one: found, nothing emitted
      csr_write(CSR_OUT_LIMIT, 64'd1);
      add_text("id=1");
      send_query();
      // limit three: two bytes, the rest dropped
      csr_write(CSR_OUT_LIMIT, 64'd3);
      add_text("id=abc");
      send_query();
   endtask

   // value longer than the raw limit at the widest output limit
   task automatic test_raw_value_cut();
      logic [7:0] c;
      set_key("", 0);
      csr_write(CSR_OUT_LIMIT, 64'hFFFF);
      add_text("=");
      repeat (RAW_VALUE_LIMIT + 8) begin
         c = value_char();
         if (c == CHAR_AMP) c = CHAR_PLUS;
         query_text.push_back(c);
      end
      add_text("&x");
      send_query();
   endtask

   // receiver holds off while the sender keeps offering value bytes, so
   // the record queue fills and the input stalls
   task automatic test_result_backpressure();
      int unsigned saved_src;
      saved_src = src_idle_pct;
      set_key("v", 1);
      csr_write(CSR_OUT_LIMIT, 64'd1024);
      src_idle_pct  = 0;
      stall_request = 300;
      add_text("v=");
      repeat (40) query_text.push_back(pick_char("abcdefghijklmnop"));
      send_query();
      src_idle_pct = saved_src;
   endtask

   task automatic randomize_config();
      logic [KEY_W-1:0] bits;
      int unsigned      len;
      int unsigned      pick;
      bits = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 10) len = 0;
      else if (pick < 20) len = 8;
      else if (pick < 28) len = $urandom_range(15, 9);
      else len = $urandom_range(4, 1);
      for (int j = 0; j < MAX_KEY_BYTES; j++) begin
         if (j < len) begin
            bits[8*j +: 8] = ($urandom_range(99) < 88) ? pick_char("abk") : pick_char("&=%+");
         end
      end
      csr_write(CSR_KEY_BYTES, bits);
      csr_write(CSR_KEY_LENGTH, KEY_W'(len));
      case ($urandom_range(9))
         0: bits = '0;
         1: bits = 64'd1;
         2: bits = KEY_W'($urandom_range(4, 2));
         3: bits = 64'd7;
         4: bits = 64'hFFFF;
         5: bits = KEY_W'($urandom_range(16'hFFFF));
         default: bits = 64'd1024;
      endcase
      csr_write(CSR_OUT_LIMIT, bits);
   endtask

   // well-formed fields, the key among them often, near misses of it and
   // other names; values full of escapes
   task automatic build_field_query();
      int unsigned len;
      int unsigned fields;
      int unsigned pick;
      int unsigned start;
      len    = (cfg_key_length > MAX_KEY_BYTES) ? MAX_KEY_BYTES : cfg_key_length;
      fields = $urandom_range(4, 1);
      for (int f = 0; f < fields; f++) begin
         if (f > 0) query_text.push_back(CHAR_AMP);
         pick  = $urandom_range(99);
         start = query_text.size();
         if (pick < 60) begin
            if (pick >= 45 && pick < 52) query_text.push_back(pick_char("abk"));
            for (int j = 0; j < len; j++) query_text.push_back(cfg_key[8*j +: 8]);
            if (pick >= 52 && query_text.size() > start) begin
               query_text[$urandom_range(query_text.size() - 1, start)] = pick_char("abk");
            end
         end else begin
            repeat ($urandom_range(4)) query_text.push_back(pick_char("abk"));
         end
         if ($urandom_range(99) < 85) query_text.push_back(CHAR_EQ);
         repeat ($urandom_range(10)) query_text.push_back(value_char());
      end
      // a zero key character cannot go on the wire
      foreach (query_text[i]) if (query_text[i] == 8'd0) query_text[i] = CHAR_LA;
      if (query_text.size() == 0) query_text.push_back(CHAR_EQ);
   endtask

   task automatic build_noise_query();
      repeat ($urandom_range(12, 1)) begin
         if ($urandom_range(99) < 40) query_text.push_back(pick_char("=&%+abk"));
         else query_text.push_back(8'($urandom_range(255, 1)));
      end
   endtask

   task automatic test_random_queries(input int unsigned src_pct, input int unsigned sink_pct,
                                      input int unsigned item_goal);
      int unsigned start;
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      randomize_config();
      start = bytes_accepted;
      while (bytes_accepted - start < item_goal) begin
         if ($urandom_range(99) < 25) randomize_config();
         if ($urandom_range(99) < 20) build_noise_query();
         else build_field_query();
         send_query();
      end
   endtask

   // ---------------------------------------------------------------
   // run
   // ---------------------------------------------------------------

   initial begin
      // every block input known from time zero
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.query_byte = 8'd0;
      req_chan.query_last = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = CSR_KEY_BYTES;
      csr_chan.data       = '0;
      // predictor starts from the reset state of the block
      cfg_key         = '0;
      cfg_key_length  = '0;
      cfg_out_limit   = OUT_LIMIT_RESET;
      restart_query();
      src_idle_pct    = 27;
      sink_idle_pct   = 46;
      stall_request   = 0;
      bytes_accepted  = 0;
      queries_seen    = 0;
      results_checked = 0;
      error_count     = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part under the first idling mix
      test_reset_defaults();
      test_percent_decoding();
      test_missing_key();
      test_literal_key_chars();
      test_output_limit();
      test_raw_value_cut();
      test_result_backpressure();

      // random part: receiver idles more, then sender more, then neither
      test_random_queries(27, 46, 127);
      test_random_queries(46, 27, 127);
      test_random_queries(0, 0, 127);

      settle();
      repeat (10) @(posedge clock);
      if (value_results.size() != 0) begin
         $error("%0d expected results never arrived", value_results.size());
         error_count++;
      end
      $display("covered %0d query bytes in %0d queries, %0d results compared",
               bytes_accepted, queries_seen, results_checked);
      $display("escapes, key edge cases, output and raw limits, long result stall, 3 idle mixes");
      if (error_count == 0) begin
         $display("query_param_extract_decode_tb: done, clean");
      end else begin
         $display("query_param_extract_decode_tb: done, errors");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("query_param_extract_decode_tb: done, errors");
      $finish;
   end

endmodule
